### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions for the double-ended queue
// Ring depth, derived widths, request and status codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH   = 8;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int OCC_W   = 4;

   localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
   localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
   localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
   localparam logic [1:0] REQ_POP_REAR   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic accept;     // transfer on the request channel this cycle
      logic load_now;   // result is complete at accept time
      logic load_pop;   // result takes the slot read data
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pop_read;   // presented request is a pop that reads a slot
   } dp_stat_type;

endpackage

### rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl: request/response controller
// Sequences one request at a time: accept, optional slot read, result load,
// and holds the result valid while the receiver stalls.
// ----------------------------------------------------------------------------
module deq_ctrl
   import deq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   // output register can take a new result this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall  = !rsp_free;
            cmd.accept = req_valid && rsp_free;
            if (cmd.accept) begin
               if (stat.pop_read) begin
                  state_in = S_READ;
               end else begin
                  cmd.load_now = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_READ: begin
            if (rsp_free) begin
               cmd.load_pop = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp: double-ended queue datapath
// Ring pointers, fill count, slot RAM and the result payload registers.
// ----------------------------------------------------------------------------
module deq_dp
   import deq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output dp_stat_type              stat,
   input  logic [1:0]               req_type,
   input  logic signed [DATA_W-1:0] req_push_value,
   output logic signed [DATA_W-1:0] rsp_pop_value,
   output logic [1:0]               rsp_status,
   output logic [OCC_W-1:0]         rsp_occupancy
);

   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(DEPTH);

   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [ADDR_W-1:0]  tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic signed [DATA_W-1:0] pop_value_ff;
   logic [1:0]         status_ff, status_in;
   logic [OCC_W-1:0]   occupancy_ff;

   logic [ADDR_W-1:0]  head_next, head_prev, tail_next, tail_prev;
   logic               is_push, full, empty;
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [DATA_W-1:0]  rd_data;

   assign head_next = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? LAST_ADDR : head_ff - 1'b1;
   assign tail_next = (tail_ff == LAST_ADDR) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_ADDR : tail_ff - 1'b1;

   assign is_push = (req_type == REQ_PUSH_FRONT) || (req_type == REQ_PUSH_REAR);
   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);

   assign stat.pop_read = !is_push && !empty;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_addr   = head_ff;
      if (is_push) begin
         if (full) begin
            status_in = ST_OVERFLOW;
         end else begin
            count_in = count_ff + 1'b1;
            wr_en    = cmd.accept;
            if (req_type == REQ_PUSH_FRONT) begin
               head_in = head_prev;
               wr_addr = head_prev;
            end else begin
               tail_in = tail_next;
            end
         end
      end else begin
         if (empty) begin
            status_in = ST_UNDERFLOW;
         end else begin
            count_in = count_ff - 1'b1;
            rd_en    = cmd.accept;
            if (req_type == REQ_POP_FRONT) begin
               head_in = head_next;
            end else begin
               tail_in = tail_prev;
               rd_addr = tail_prev;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // result payload: status and occupancy are settled at accept time
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         status_ff    <= status_in;
         occupancy_ff <= OCC_W'(count_in);
      end
      if (cmd.load_now) begin
         pop_value_ff <= '0;
      end else if (cmd.load_pop) begin
         pop_value_ff <= rd_data;
      end
   end

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_pop_value = pop_value_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occupancy_ff;

endmodule

### rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// Requests push or pop a word at either end of a ring of DEPTH slots; each
// request returns one result with the popped word, a status and occupancy.
//
// Usage:
//   Request channel (req_valid / req_stall): req_type selects push front,
//   push rear, pop front or pop rear; req_push_value is the word to store.
//   Result channel (rsp_valid / rsp_stall): rsp_pop_value, rsp_status
//   (ok, overflow, underflow) and rsp_occupancy after the request.
//   Result timing: a push or a failed pop shows its result in the cycle
//   after the transfer; a successful pop first waits in the read state
//   for the registered read of the slot RAM, then loads its result.
//   Throughput: 1 request per cycle for pushes and failed pops while the
//   result side does not stall; a successful pop blocks new requests until its slot RAM read is loaded.
//   A new request is taken while the previous result is being handed over.
//   Reset clears pointers, fill count and the result valid; slot contents
//   are left as they are. While rsp_stall holds a result, req_stall is
//   raised and no request is taken.
// ----------------------------------------------------------------------------
module double_ended_queue
   import deq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_type,
   input  logic signed [DATA_W-1:0] req_push_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_pop_value,
   output logic [1:0]               rsp_status,
   output logic [OCC_W-1:0]         rsp_occupancy
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // handshake sequencing: accept, wait for slot read, hold result
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // pointers, fill count, slot RAM and result registers
   deq_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

`ifndef NO_ASSERTIONS
   // a held result must block new requests
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while result held");

   // a result appears only after the controller loaded one
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_now || cmd.load_pop))
      else $error("result valid without a load");

   // failed requests return zero data
   a_error_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_pop_value == '0))
      else $error("nonzero data on failed request");

   // accept and pop load never coincide
   a_load_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.load_pop))
      else $error("accept during pop read");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for double_ended_queue
// Pushes and pops words at both ends of the ring and predicts every result
// (popped word, status, occupancy) with a shadow copy of the deque. Directed
// tests hit empty, full, the word extremes and pointer wrap; a long random
// run then walks the occupancy up and down with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
   import deq_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;   // cycles without any transfer
   localparam int RANDOM_ITEMS   = 1330;
   localparam int PHASE_LEN      = 50;

   typedef struct {
      logic signed [DATA_W-1:0] word;
      logic [1:0]               status;
      logic [OCC_W-1:0]         occ;
   } deq_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_type = REQ_PUSH_REAR;
   logic signed [DATA_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_pop_value;
   logic [1:0]               rsp_status;
   logic [OCC_W-1:0]         rsp_occupancy;

   // shadow deque: ring contents, front position, one-past-rear position, fill
   logic signed [DATA_W-1:0] shadow_ring [DEPTH];
   int front_pos = 0;
   int back_pos  = 0;
   int held      = 0;

   deq_result_type owed_responses [$];

   bit idle_on    = 1'b1;   // both sides insert gaps and stalls when set
   int hold_left  = 0;      // remaining stall cycles on the result side
   int fail_count = 0;
   int rsp_count  = 0;
   int overflows  = 0;
   int underflows = 0;
   int idle_run   = 0;
   int kind_count [4] = '{0, 0, 0, 0};

   double_ended_queue dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Apply one request to the shadow deque and return the result it owes.
   // A refused push or pop leaves the shadow untouched and returns zero data.
   function automatic deq_result_type apply_request(input logic [1:0] kind,
                                                    input logic signed [DATA_W-1:0] word);
      deq_result_type r;
      r.word   = '0;
      r.status = ST_OK;
      case (kind)
         REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
            if (held == DEPTH) begin
               r.status = ST_OVERFLOW;
               overflows++;
            end else if (kind == REQ_PUSH_FRONT) begin
               // step the front back first, wrapping below slot zero
               front_pos = (front_pos + DEPTH - 1) % DEPTH;
               shadow_ring[front_pos] = word;
               held++;
            end else begin
               shadow_ring[back_pos] = word;
               back_pos = (back_pos + 1) % DEPTH;
               held++;
            end
         end
         default: begin
            if (held == 0) begin
               r.status = ST_UNDERFLOW;
               underflows++;
            end else if (kind == REQ_POP_FRONT) begin
               r.word    = shadow_ring[front_pos];
               front_pos = (front_pos + 1) % DEPTH;
               held--;
            end else begin
               // the rear word sits one slot behind the rear position
               back_pos = (back_pos + DEPTH - 1) % DEPTH;
               r.word   = shadow_ring[back_pos];
               held--;
            end
         end
      endcase
      r.occ = OCC_W'(held);
      return r;
   endfunction

   // Send one request: optional gap, then hold the payload until the
   // transfer, and log what the deque owes for it. Valid stays high on
   // exit so back-to-back requests never drop it within one step.
   task automatic send_request(input logic [1:0] kind,
                               input logic signed [DATA_W-1:0] word);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_push_value <= word;
      do @(posedge clock); while (req_stall);
      owed_responses.push_back(apply_request(kind, word));
      kind_count[kind]++;
   endtask

   // Result side: check every transfer against the oldest owed result, then
   // draw how long to stall before taking the next one.
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (owed_responses.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("[%0t] unexpected result: data %0d status %0d occupancy %0d",
                        $realtime, rsp_pop_value, rsp_status, rsp_occupancy);
         end else begin
            deq_result_type want;
            want = owed_responses.pop_front();
            if (rsp_pop_value !== want.word || rsp_status !== want.status ||
                rsp_occupancy !== want.occ) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] mismatch data/status/occ: exp %0d/%0d/%0d got %0d/%0d/%0d",
                           $realtime, want.word, want.status, want.occ,
                           rsp_pop_value, rsp_status, rsp_occupancy);
            end
         end
         hold_left = idle_on ? $urandom_range(0, 3) : 0;
      end else if (hold_left > 0) begin
         hold_left--;
      end
      rsp_stall <= (hold_left > 0);
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_run <= 0;
      end else if (idle_run + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   // Pops on an empty deque from either end.
   task automatic test_empty_underflow();
      send_request(REQ_POP_FRONT, 32'sh1234_5678);
      send_request(REQ_POP_REAR, -32'sd1);
   endtask

   // Fill from both ends with extreme words (the front push wraps below slot
   // zero), then refuse one push at each end.
   task automatic test_full_overflow();
      send_request(REQ_PUSH_REAR, 32'sh7FFF_FFFF);
      send_request(REQ_PUSH_REAR, 32'sh8000_0000);
      send_request(REQ_PUSH_REAR, -32'sd1);
      send_request(REQ_PUSH_REAR, 32'sd0);
      send_request(REQ_PUSH_FRONT, 32'sd1);
      send_request(REQ_PUSH_FRONT, 32'shAAAA_AAAA);
      send_request(REQ_PUSH_FRONT, 32'sh5555_5555);
      send_request(REQ_PUSH_FRONT, 32'sd2);
      send_request(REQ_PUSH_FRONT, 32'sd3);
      send_request(REQ_PUSH_REAR, 32'sd4);
   endtask

   // Drain alternately from both ends, then underflow once more.
   task automatic test_drain_both_ends();
      repeat (DEPTH / 2) begin
         send_request(REQ_POP_FRONT, 32'sd0);
         send_request(REQ_POP_REAR, 32'sd0);
      end
      send_request(REQ_POP_REAR, 32'sd0);
   endtask

   // Push at one end and pop at the other so each pointer moves both ways.
   task automatic test_ring_wrap();
      send_request(REQ_PUSH_FRONT, 32'sh0F0F_0F0F);
      send_request(REQ_POP_REAR, 32'sd0);
      send_request(REQ_PUSH_REAR, 32'shF0F0_F0F0);
      send_request(REQ_POP_FRONT, 32'sd0);
   endtask

   // Random traffic in phases: each phase leans toward filling, draining or
   // neither, so occupancy sweeps from empty to full and back many times.
   task automatic test_random_traffic();
      int push_pct;
      int pick;
      logic [1:0] kind;
      logic signed [DATA_W-1:0] word;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_LEN == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 75;
               1:       push_pct = 25;
               default: push_pct = 50;
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 99) < push_pct)
            kind = $urandom_range(0, 1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
         else
            kind = $urandom_range(0, 1) ? REQ_POP_REAR : REQ_POP_FRONT;
         pick = $urandom_range(0, 9);
         case (pick)
            0:       word = 32'sh7FFF_FFFF;
            1:       word = 32'sh8000_0000;
            2:       word = 32'sd0;
            3:       word = -32'sd1;
            default: word = $urandom;
         endcase
         send_request(kind, word);
      end
   endtask

   initial begin
      foreach (shadow_ring[i]) shadow_ring[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_underflow();
      test_full_overflow();
      test_drain_both_ends();
      test_ring_wrap();
      test_random_traffic();

      // drop valid after the last transfer and let the results drain
      req_valid <= 1'b0;
      idle_on = 1'b1;
      while (owed_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("requests: %0d push front, %0d push rear, %0d pop front, %0d pop rear",
               kind_count[REQ_PUSH_FRONT], kind_count[REQ_PUSH_REAR],
               kind_count[REQ_POP_FRONT], kind_count[REQ_POP_REAR]);
      $display("results checked: %0d (%0d overflows, %0d underflows), mismatches: %0d",
               rsp_count, overflows, underflows, fail_count);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue.sv
bench/tb.sv
